// ===== hw/rtl/sirt_pkg.sv =====
// Package for the signed integer to radix text core: beat types, sizes and
// the digit character lookup. Depends on nothing; every other file imports it.
package sirt_pkg;

	localparam int VALUE_W    = 64;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;
	localparam int MAX_DIGITS = 64;
	localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int DIV_BITS   = 8;
	localparam int CHUNKS     = VALUE_W / DIV_BITS;
	localparam int CHUNK_W    = $clog2(CHUNKS);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(35);
	localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [RADIX_W-1:0]        radix;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic              bad_radix;
	} out_beat_t;

	// Digits 0-9 then A-Z; codes past Z fall back to '0'.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(10)) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else if (d < DIGIT_W'(36)) begin
			c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/signed_integer_to_radix_text_core.sv =====
// Top level of the signed integer to radix text core: sequencer, digit store
// and result register. Depends on sirt_pkg and sirt_div_step.
//
//   port      direction  beat               handshake
//   operand   in         value, radix       taken when start is high and busy low
//   result    out        character, last,   one cycle, marked by strobe
//                        bad_radix
//
// A bad radix gives its single result in the cycle after acceptance and never
// raises busy. Otherwise each digit passes all CHUNKS (8) dividend chunks through
// the shared divider, which handles eight dividend bits per cycle. The sign of a
// negative value leaves in the cycle after the last division step, then the digits
// leave one per cycle, and the next beat can be taken as the last digit is shown.
// Reset clears the sequencer and the strobe; the digit store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module signed_integer_to_radix_text_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sirt_pkg::in_beat_t  operand,
	output logic                strobe,
	output sirt_pkg::out_beat_t result
);
	import sirt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [CHUNK_W-1:0]  chunk_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic                rd_valid_s1;
	logic                rd_last_s1;
	logic [DIGIT_W-1:0]  rd_data_s1;
	logic                strobe_q;
	out_beat_t           result_q;

	logic [VALUE_W-1:0]  dividend_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  radix_q;
	logic                neg_q;

	logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];

	logic                accept;
	logic                bad;
	logic [VALUE_W-1:0]  val_u;
	logic [VALUE_W-1:0]  mag_raw;
	logic [VALUE_W-1:0]  mag;
	logic [DIGIT_W-1:0]  rem_nxt;
	logic [DIV_BITS-1:0] quot_bits;
	logic [VALUE_W-1:0]  quot_nxt;
	logic                digit_done;
	logic                conv_done;
	logic                store_room;
	logic [COUNT_W-1:0]  count_inc;

	sirt_div_step u_div_step (
		.rem_in    (rem_q),
		.chunk     (dividend_q[VALUE_W-1 -: DIV_BITS]),
		.radix     (radix_q),
		.rem_out   (rem_nxt),
		.quot_bits (quot_bits)
	);

	always_comb begin
		busy       = (state_q != ST_IDLE) || rd_valid_s1;
		accept     = start && !busy;
		bad        = (operand.radix < RADIX_MIN) || (operand.radix > RADIX_MAX);
		val_u      = operand.value;
		mag_raw    = val_u[VALUE_W-1] ? (~val_u + VALUE_W'(1)) : val_u;
		mag        = mag_raw[VALUE_W-1] ? MAG_LIMIT : mag_raw;
		quot_nxt   = {dividend_q[VALUE_W-DIV_BITS-1:0], quot_bits};
		digit_done = (state_q == ST_DIV) && (chunk_q == CHUNK_W'(CHUNKS - 1));
		conv_done  = digit_done && (quot_nxt == '0);
		store_room = count_q < COUNT_W'(MAX_DIGITS);
		count_inc  = store_room ? count_q + COUNT_W'(1) : count_q;
		strobe     = strobe_q;
		result     = result_q;
	end

	// Sequencer and strobes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// The final digit read may still be in flight here.
					rd_valid_s1 <= 1'b0;
					strobe_q    <= rd_valid_s1 || (accept && bad);
					if (accept) begin
						count_q <= '0;
						chunk_q <= '0;
						if (!bad) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rd_valid_s1 <= 1'b0;
					strobe_q    <= conv_done && neg_q;
					chunk_q     <= chunk_q + CHUNK_W'(1);
					if (digit_done) begin
						count_q <= count_inc;
					end
					if (conv_done) begin
						state_q  <= ST_EMIT;
						rd_idx_q <= ADDR_W'(count_inc - COUNT_W'(1));
					end
				end
				ST_EMIT: begin
					strobe_q    <= rd_valid_s1;
					rd_valid_s1 <= 1'b1;
					rd_last_s1  <= (rd_idx_q == '0);
					rd_idx_q    <= rd_idx_q - ADDR_W'(1);
					if (rd_idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					rd_valid_s1 <= 1'b0;
					strobe_q    <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand, divider and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q    <= operand.radix;
			neg_q      <= val_u[VALUE_W-1];
			dividend_q <= mag;
			rem_q      <= '0;
			if (bad) begin
				result_q <= '{character: CHAR_NONE, last: 1'b1, bad_radix: 1'b1};
			end
		end else if (state_q == ST_DIV) begin
			dividend_q <= quot_nxt;
			rem_q      <= digit_done ? '0 : rem_nxt;
			if (conv_done && neg_q) begin
				result_q <= '{character: CHAR_MINUS, last: 1'b0, bad_radix: 1'b0};
			end
		end else if (rd_valid_s1) begin
			result_q <= '{character: digit_char(rd_data_s1), last: rd_last_s1,
				bad_radix: 1'b0};
		end
	end

	// Digit store, least significant digit at address zero.
	always_ff @(posedge clk) begin
		if (digit_done && store_room) begin
			digit_mem[count_q[ADDR_W-1:0]] <= rem_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			rd_data_s1 <= digit_mem[rd_idx_q];
		end
	end

	a_bad_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.bad_radix |-> result.last && $past(start && !busy))
		else $error("bad radix result without a matching accepted beat");

	a_good_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operand.radix >= RADIX_MIN && operand.radix <= RADIX_MAX
		|=> busy)
		else $error("valid operand accepted but the core did not go busy");

	a_read_gives_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |=> strobe && !result.bad_radix)
		else $error("digit read did not produce a result beat");

	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("core still busy when the final character left");

endmodule

// ===== hw/rtl/sirt_div_step.sv =====
// One step of the shared long divider: brings DIV_BITS dividend bits through
// the restoring compare-and-subtract chain. Depends on sirt_pkg.
module sirt_div_step (
	input  logic [sirt_pkg::DIGIT_W-1:0]  rem_in,
	input  logic [sirt_pkg::DIV_BITS-1:0] chunk,
	input  logic [sirt_pkg::RADIX_W-1:0]  radix,
	output logic [sirt_pkg::DIGIT_W-1:0]  rem_out,
	output logic [sirt_pkg::DIV_BITS-1:0] quot_bits
);
	import sirt_pkg::*;

	// The remainder stays below the radix, so it never needs more than six bits.
	always_comb begin
		logic [DIGIT_W-1:0] r;
		logic [DIGIT_W:0]   t;
		r = rem_in;
		quot_bits = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= {1'b0, radix}) begin
				r = DIGIT_W'(t - {1'b0, radix});
				quot_bits[i] = 1'b1;
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_out = r;
	end

endmodule
